// ----- src/ucrh_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ucrh_pkg: shared types and constants of the control request handler
// Request, command and result records, action codes, request codes,
// descriptor identifiers and configuration register indexes.
// ----------------------------------------------------------------------------
package ucrh_pkg;

    // Endpoint-0 maximum packet size in bytes (8 to 64)
    localparam int EP0_PACKET_BYTES = 64;
    localparam logic [7:0] EP0_PKT_LEN  = 8'(EP0_PACKET_BYTES);
    localparam logic [6:0] EP0_PKT_CNT  = 7'(EP0_PACKET_BYTES);

    // Command queue between classifier and packetizer
    localparam int CMD_DEPTH  = 2;
    localparam int CMD_PTR_W  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

    // Configuration registers
    localparam int CFG_COUNT = 6;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_LEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIG_LEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUF_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_LEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HID_IF      = 3'd5;

    localparam logic [7:0] RST_DEVICE_LEN  = 8'd18;
    localparam logic [7:0] RST_CONFIG_LEN  = 8'd41;
    localparam logic [7:0] RST_REPORT_LEN  = 8'd64;
    localparam logic [7:0] RST_MANUF_LEN   = 8'd2;
    localparam logic [7:0] RST_PRODUCT_LEN = 8'd2;
    localparam logic [7:0] RST_HID_IF      = 8'd0;
    localparam logic [7:0] RST_PROTOCOL    = 8'd1;

    // Input operations
    localparam logic OP_SETUP     = 1'b0;
    localparam logic OP_BUS_RESET = 1'b1;

    // bRequest codes (standard and HID class)
    localparam logic [7:0] REQ_GET_STATUS     = 8'h00;
    localparam logic [7:0] REQ_GET_REPORT     = 8'h01;
    localparam logic [7:0] REQ_GET_IDLE       = 8'h02;
    localparam logic [7:0] REQ_GET_PROTOCOL   = 8'h03;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIG     = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
    localparam logic [7:0] REQ_SET_REPORT     = 8'h09;
    localparam logic [7:0] REQ_SET_IDLE       = 8'h0A;
    localparam logic [7:0] REQ_SET_PROTOCOL   = 8'h0B;

    // bmRequestType values
    localparam logic [7:0] RT_STD_OUT   = 8'h00;
    localparam logic [7:0] RT_STD_IN    = 8'h80;
    localparam logic [7:0] RT_CLASS_IN  = 8'hA1;
    localparam logic [7:0] RT_CLASS_OUT = 8'h21;

    // Descriptor wValue / wIndex keys
    localparam logic [15:0] DV_DEVICE   = 16'h0100;
    localparam logic [15:0] DV_CONFIG   = 16'h0200;
    localparam logic [15:0] DV_HID      = 16'h2100;
    localparam logic [15:0] DV_REPORT   = 16'h2200;
    localparam logic [15:0] DV_LANGID   = 16'h0300;
    localparam logic [15:0] DV_MANUF    = 16'h0301;
    localparam logic [15:0] DV_PRODUCT  = 16'h0302;
    localparam logic [15:0] LANG_EN_US  = 16'h0409;

    localparam logic [7:0] HID_DESC_LEN    = 8'd9;
    localparam logic [7:0] LANGID_DESC_LEN = 8'd4;
    localparam logic [7:0] LEN_CAP         = 8'd255;

    // Descriptor table entries
    localparam logic [2:0] DSC_DEVICE  = 3'd0;
    localparam logic [2:0] DSC_CONFIG  = 3'd1;
    localparam logic [2:0] DSC_HID     = 3'd2;
    localparam logic [2:0] DSC_REPORT  = 3'd3;
    localparam logic [2:0] DSC_LANGID  = 3'd4;
    localparam logic [2:0] DSC_MANUF   = 3'd5;
    localparam logic [2:0] DSC_PRODUCT = 3'd6;

    typedef enum logic [3:0] {
        ACT_STALL         = 4'd0,
        ACT_DESC          = 4'd1,
        ACT_REPLY         = 4'd2,
        ACT_HANDSHAKE     = 4'd3,
        ACT_SET_ADDRESS   = 4'd4,
        ACT_CONFIGURE     = 4'd5,
        ACT_INIT_REPORT   = 4'd6,
        ACT_OUT_HANDSHAKE = 4'd7,
        ACT_RESET_DONE    = 4'd8
    } t_action;

    typedef struct packed {
        logic        operation;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_index;
        logic [15:0] request_length;
    } t_request;

    typedef struct packed {
        t_action     action;
        logic [2:0]  descriptor_select;
        logic [7:0]  byte_offset;
        logic [6:0]  byte_count;
        logic [7:0]  reply_value;
        logic [1:0]  reply_bytes;
        logic [6:0]  device_address;
        logic [7:0]  configuration_now;
        logic        last;
    } t_result;

    // One classified request, as handed from front to back
    typedef struct packed {
        t_action     action;
        logic [2:0]  descriptor_select;
        logic [7:0]  length;
        logic [7:0]  reply_value;
        logic [1:0]  reply_bytes;
        logic [6:0]  device_address;
        logic [7:0]  configuration_now;
    } t_cmd;

endpackage
`default_nettype wire

// ----- src/ucrh_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ucrh_front: request classifier
// Holds the configuration registers and device state, decodes each accepted
// request or bus reset combinationally and pushes one command into the queue.
// ----------------------------------------------------------------------------
module ucrh_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [ucrh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                   i_cfg_data,
    input  wire logic                         i_accept,
    input  wire ucrh_pkg::t_request           i_request,
    output      ucrh_pkg::t_cmd               o_cmd
);
    import ucrh_pkg::*;

    logic [7:0] r_cfg [CFG_COUNT];
    logic [7:0] r_configuration, n_configuration;
    logic [7:0] r_idle_rate, n_idle_rate;
    logic [7:0] r_protocol, n_protocol;
    logic [6:0] r_address, n_address;
    logic       r_addr_en, n_addr_en;

    logic       desc_hit;
    logic [2:0] desc_sel;
    logic [7:0] desc_len;
    logic [7:0] req_len_cap;
    logic [7:0] xfer_len;
    logic       hid_match;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[CFG_DEVICE_LEN]  <= RST_DEVICE_LEN;
            r_cfg[CFG_CONFIG_LEN]  <= RST_CONFIG_LEN;
            r_cfg[CFG_REPORT_LEN]  <= RST_REPORT_LEN;
            r_cfg[CFG_MANUF_LEN]   <= RST_MANUF_LEN;
            r_cfg[CFG_PRODUCT_LEN] <= RST_PRODUCT_LEN;
            r_cfg[CFG_HID_IF]      <= RST_HID_IF;
        end else if (i_cfg_we && (i_cfg_index < CFG_IDX_W'(CFG_COUNT))) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // Look up the descriptor table, first match wins
    assign hid_match = (i_request.request_index == {8'h00, r_cfg[CFG_HID_IF]});

    always_comb begin
        desc_hit = 1'b1;
        desc_sel = DSC_DEVICE;
        desc_len = r_cfg[CFG_DEVICE_LEN];
        if (i_request.request_value == DV_DEVICE && i_request.request_index == 16'h0000) begin
            desc_sel = DSC_DEVICE;
            desc_len = r_cfg[CFG_DEVICE_LEN];
        end else if (i_request.request_value == DV_CONFIG
                     && i_request.request_index == 16'h0000) begin
            desc_sel = DSC_CONFIG;
            desc_len = r_cfg[CFG_CONFIG_LEN];
        end else if (i_request.request_value == DV_HID && hid_match) begin
            desc_sel = DSC_HID;
            desc_len = HID_DESC_LEN;
        end else if (i_request.request_value == DV_REPORT && hid_match) begin
            desc_sel = DSC_REPORT;
            desc_len = r_cfg[CFG_REPORT_LEN];
        end else if (i_request.request_value == DV_LANGID
                     && i_request.request_index == 16'h0000) begin
            desc_sel = DSC_LANGID;
            desc_len = LANGID_DESC_LEN;
        end else if (i_request.request_value == DV_MANUF
                     && i_request.request_index == LANG_EN_US) begin
            desc_sel = DSC_MANUF;
            desc_len = r_cfg[CFG_MANUF_LEN];
        end else if (i_request.request_value == DV_PRODUCT
                     && i_request.request_index == LANG_EN_US) begin
            desc_sel = DSC_PRODUCT;
            desc_len = r_cfg[CFG_PRODUCT_LEN];
        end else begin
            desc_hit = 1'b0;
        end
    end

    // Clamp the transfer length to the request, to one byte of range and to the descriptor length
    assign req_len_cap = (|i_request.request_length[15:8]) ? LEN_CAP
                                                            : i_request.request_length[7:0];
    assign xfer_len    = (req_len_cap > desc_len) ? desc_len : req_len_cap;

    // Classify the request and work out the next device state
    always_comb begin
        n_configuration = r_configuration;
        n_idle_rate     = r_idle_rate;
        n_protocol      = r_protocol;
        n_address       = r_address;
        n_addr_en       = r_addr_en;

        o_cmd                   = '0;
        o_cmd.action            = ACT_STALL;

        if (i_request.operation == OP_BUS_RESET) begin
            n_configuration = 8'h00;
            o_cmd.action    = ACT_RESET_DONE;
        end else if (i_request.request_code == REQ_GET_DESCRIPTOR) begin
            if (desc_hit) begin
                o_cmd.action            = ACT_DESC;
                o_cmd.descriptor_select = desc_sel;
                o_cmd.length            = xfer_len;
            end
        end else if (i_request.request_code == REQ_SET_ADDRESS) begin
            n_address    = i_request.request_value[6:0];
            n_addr_en    = 1'b1;
            o_cmd.action = ACT_SET_ADDRESS;
        end else if (i_request.request_code == REQ_SET_CONFIG
                     && i_request.request_type == RT_STD_OUT) begin
            n_configuration = i_request.request_value[7:0];
            o_cmd.action    = ACT_CONFIGURE;
        end else if (i_request.request_code == REQ_GET_CONFIG
                     && i_request.request_type == RT_STD_IN) begin
            o_cmd.action      = ACT_REPLY;
            o_cmd.reply_value = r_configuration;
            o_cmd.reply_bytes = 2'd1;
        end else if (i_request.request_code == REQ_GET_STATUS) begin
            o_cmd.action      = ACT_REPLY;
            o_cmd.reply_bytes = 2'd2;
        end else if (hid_match && i_request.request_type == RT_CLASS_IN) begin
            case (i_request.request_code)
                REQ_GET_REPORT: begin
                    o_cmd.action = ACT_INIT_REPORT;
                end
                REQ_GET_IDLE: begin
                    o_cmd.action      = ACT_REPLY;
                    o_cmd.reply_value = r_idle_rate;
                    o_cmd.reply_bytes = 2'd1;
                end
                REQ_GET_PROTOCOL: begin
                    o_cmd.action      = ACT_REPLY;
                    o_cmd.reply_value = r_protocol;
                    o_cmd.reply_bytes = 2'd1;
                end
                default: begin
                    o_cmd.action = ACT_STALL;
                end
            endcase
        end else if (hid_match && i_request.request_type == RT_CLASS_OUT) begin
            case (i_request.request_code)
                REQ_SET_REPORT: begin
                    o_cmd.action = ACT_OUT_HANDSHAKE;
                end
                REQ_SET_IDLE: begin
                    n_idle_rate  = i_request.request_value[15:8];
                    o_cmd.action = ACT_HANDSHAKE;
                end
                REQ_SET_PROTOCOL: begin
                    n_protocol   = i_request.request_value[7:0];
                    o_cmd.action = ACT_HANDSHAKE;
                end
                default: begin
                    o_cmd.action = ACT_STALL;
                end
            endcase
        end

        // Snapshot the state as it stands after this request
        o_cmd.device_address    = n_addr_en ? n_address : 7'd0;
        o_cmd.configuration_now = n_configuration;
    end

    // Commit the state on a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_configuration <= 8'h00;
            r_idle_rate     <= 8'h00;
            r_protocol      <= RST_PROTOCOL;
            r_address       <= 7'd0;
            r_addr_en       <= 1'b0;
        end else if (i_accept) begin
            r_configuration <= n_configuration;
            r_idle_rate     <= n_idle_rate;
            r_protocol      <= n_protocol;
            r_address       <= n_address;
            r_addr_en       <= n_addr_en;
        end
    end

endmodule
`default_nettype wire

// ----- src/ucrh_cmd_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ucrh_cmd_fifo: command queue
// Short first-in first-out queue of classified commands between the
// classifier and the packetizer; the head is visible while not empty.
// ----------------------------------------------------------------------------
module ucrh_cmd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ucrh_pkg::t_cmd i_cmd,
    output      logic           o_full,
    input  wire logic           i_pop,
    output      logic           o_empty,
    output      ucrh_pkg::t_cmd o_head
);
    import ucrh_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CMD_CNT_W-1:0] r_count;
    logic                 do_push, do_pop;

    assign o_full  = (r_count == CMD_CNT_W'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CMD_CNT_W'(CMD_DEPTH))
        else $error("command queue occupancy beyond depth");

endmodule
`default_nettype wire

// ----- src/ucrh_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ucrh_back: result packetizer
// Takes the command at the queue head and emits its results into the output
// register, splitting descriptor transfers into endpoint-0 packets.
// ----------------------------------------------------------------------------
module ucrh_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cmd_empty,
    input  wire ucrh_pkg::t_cmd  i_cmd,
    output      logic            o_cmd_pop,
    input  wire logic            i_pop,
    output      logic            o_empty,
    output      ucrh_pkg::t_result o_result
);
    import ucrh_pkg::*;

    t_result    r_out, n_out;
    logic       r_out_valid;
    logic       r_active;
    logic [7:0] r_remain, r_offset;

    logic       emit;
    logic       is_desc;
    logic [7:0] cur_remain, cur_offset, rem_next;
    logic [6:0] pkt_n;
    logic       desc_last;

    assign emit    = !i_cmd_empty && (!r_out_valid || i_pop);
    assign is_desc = (i_cmd.action == ACT_DESC);

    // Size the next descriptor packet
    assign cur_remain = r_active ? r_remain : i_cmd.length;
    assign cur_offset = r_active ? r_offset : 8'h00;
    assign pkt_n      = (cur_remain >= EP0_PKT_LEN) ? EP0_PKT_CNT : cur_remain[6:0];
    assign rem_next   = cur_remain - {1'b0, pkt_n};
    assign desc_last  = (rem_next == 8'h00) && (pkt_n != EP0_PKT_CNT);

    // Build the next result
    always_comb begin
        n_out                   = '0;
        n_out.action            = i_cmd.action;
        n_out.reply_value       = i_cmd.reply_value;
        n_out.reply_bytes       = i_cmd.reply_bytes;
        n_out.device_address    = i_cmd.device_address;
        n_out.configuration_now = i_cmd.configuration_now;
        n_out.last              = 1'b1;
        if (is_desc) begin
            n_out.descriptor_select = i_cmd.descriptor_select;
            n_out.byte_offset       = cur_offset;
            n_out.byte_count        = pkt_n;
            n_out.last              = desc_last;
        end
    end

    // Release the command once its final result goes out
    assign o_cmd_pop = emit && (!is_desc || desc_last);

    // Output register and packet progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (emit) begin
                r_active <= is_desc && !desc_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out    <= n_out;
            r_remain <= rem_next;
            r_offset <= cur_offset + {1'b0, pkt_n};
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    a_active_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> !i_cmd_empty)
        else $error("packetizer mid-transfer with no command queued");

    a_full_until_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action == ACT_DESC && !r_out.last)
            |-> (r_out.byte_count == EP0_PKT_CNT))
        else $error("short descriptor packet not marked last");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action == ACT_DESC) |-> (r_out.byte_count <= EP0_PKT_CNT))
        else $error("descriptor packet larger than endpoint-0 packet size");

endmodule
`default_nettype wire

// ----- src/usb_control_request_handler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// usb_control_request_handler: USB HID control endpoint request handler
// Decodes setup requests and bus resets, tracks device state and emits
// endpoint-0 results, descriptor transfers split into packets.
// ----------------------------------------------------------------------------
//  channel   ports                          transfer when
//  request   push, full, i_request          push && !full
//  result    empty, pop, o_result           pop && !empty
//  config    i_cfg_we, i_cfg_index, i_cfg_data  i_cfg_we
//
// A request is decoded in the cycle it is transferred; its command is written
// into the queue, and its first result is registered in the output register
// from the queue head. The packetizer emits one result per cycle while the
// output is free or being popped: one for most requests, floor(len/64)+1 for
// a descriptor of len bytes (at most 255), so a request yields 1 to 4 results.
// Reset is synchronous and restores control and state registers at once, with
// no clearing pass; queue storage and output data are not reset. A two-entry
// command queue lets the decoder take requests until full while results stall.
// ----------------------------------------------------------------------------
module usb_control_request_handler (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ucrh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                     i_cfg_data,
    input  wire logic                           push,
    output      logic                           full,
    input  wire ucrh_pkg::t_request             i_request,
    output      logic                           empty,
    input  wire logic                           pop,
    output      ucrh_pkg::t_result              o_result
);
    import ucrh_pkg::*;

    t_cmd front_cmd, head_cmd;
    logic accept, cmd_empty, cmd_pop;

    assign accept = push && !full;

    // Classify requests
    ucrh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_request   (i_request),
        .o_cmd       (front_cmd)
    );

    // Hold pending commands
    ucrh_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_head  (head_cmd)
    );

    // Emit results
    ucrh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire
